FILE: rtl/bspc_pkg.sv
// Shared constants, command and status types of the bubble sort pass counter.
`timescale 1ns / 1ps

package bspc_pkg;

  // List storage
  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VALUE_W   = 32;

  // Result fields
  localparam int PASS_W      = 11;
  localparam int PASS_MAX    = 2047;
  localparam int OUT_TDATA_W = 16;

  // Controller states
  typedef enum logic [2:0] {
    S_LOAD,
    S_KEY,
    S_KEYW,
    S_SCAN,
    S_DRAIN,
    S_EVAL,
    S_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // store the accepted input beat
    logic start;     // begin ranking: clear outer index and best
    logic key_rd;    // address the store with the outer index
    logic key_cap;   // capture key from read data, clear rank
    logic j_clr;     // clear scan index
    logic scan;      // issue read at scan index and advance it
    logic eval;      // fold displacement of this key into best
    logic i_inc;     // advance outer index
    logic out_load;  // load result register, clear list state
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic i_last;    // outer index is at the last stored entry
    logic j_last;    // scan index is at the last stored entry
  } stat_t;

endpackage

FILE: rtl/bubble_sort_pass_counter.sv
// Top level of the bubble sort pass counter: controller, datapath and checks.
//
// Input stream: one signed 32-bit value per beat on in_tdata, in_tlast on
// the final value of a list. Up to MAX_ITEMS (1024) values are stored; later
// values of the same list are dropped and flag overflow, and a dropped last
// beat still closes the list.
// Output stream: one beat per list, out_tdata[10:0] = passes (largest
// leftward displacement of any value from its sorted place, plus one),
// out_tuser = overflow.
// Timing: in_tready stays high while a list loads, one value per cycle. After
// the last beat the block ranks each stored entry by a full scan of the value
// RAM through its single read port before the result register loads; in_tready
// is low over that time.
// The result waits in an output register: the next list loads while it is
// pending, and a further result waits until out_tready takes the first.
// Reset (rst_n low, synchronous) empties the list, clears overflow and drops
// any pending result; the value RAM is not cleared.
`timescale 1ns / 1ps

module bubble_sort_pass_counter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bspc_pkg::VALUE_W-1:0]     in_tdata,   // [31:0] value
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bspc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [10:0] passes, [15:11] zero
  output logic                             out_tuser   // [0] overflow
);

  bspc_pkg::cmd_t  cmd;
  bspc_pkg::stat_t stat;

  bspc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bspc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_value (in_tdata),
    .out_data (out_tdata),
    .out_ovf  (out_tuser)
  );

  // Never overwrite a result that is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result register loaded over a pending beat");

  // Stop taking beats once a list is closed
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input accepted right after list close");

  // Key capture comes in the cycle after its read
  a_key_timing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.key_cap |-> $past(cmd.key_rd))
    else $error("key captured without a preceding read");

  // A loaded result shows on the port next cycle
  a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");

endmodule

FILE: rtl/bspc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bspc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bspc_dp.sv
// Datapath: value store, indices, rank counter, best displacement and result register.
`timescale 1ns / 1ps

module bspc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bspc_pkg::cmd_t                  cmd,
  output bspc_pkg::stat_t                 stat,
  input  logic [bspc_pkg::VALUE_W-1:0]    in_value,
  output logic [bspc_pkg::OUT_TDATA_W-1:0] out_data,
  output logic                            out_ovf
);

  localparam int AW = bspc_pkg::ADDR_W;
  localparam int CW = bspc_pkg::CNT_W;

  logic [CW-1:0]                   cnt_r;
  logic                            ovf_r;
  logic [AW-1:0]                   i_r;
  logic [AW-1:0]                   j_r;
  logic [AW-1:0]                   jd_r;
  logic                            cmp_vld_r;
  logic [bspc_pkg::VALUE_W-1:0]    key_r;
  logic [AW-1:0]                   rank_r;
  logic [AW-1:0]                   best_r;
  logic [bspc_pkg::PASS_W-1:0]     passes_r;
  logic                            out_ovf_r;

  logic                            full;
  logic                            we;
  logic [AW-1:0]                   raddr;
  logic [bspc_pkg::VALUE_W-1:0]    rdata;
  logic                            smaller;
  logic [AW-1:0]                   disp;
  logic [31:0]                     sum;
  logic [bspc_pkg::PASS_W-1:0]     passes_nxt;

  // Store and read addressing
  assign full  = (cnt_r == CW'(bspc_pkg::MAX_ITEMS));
  assign we    = cmd.load && !full;
  assign raddr = cmd.key_rd ? i_r : j_r;

  bspc_ram #(
    .WIDTH (bspc_pkg::VALUE_W),
    .DEPTH (bspc_pkg::MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status toward the controller
  assign stat.i_last = ((CW'(i_r) + CW'(1)) == cnt_r);
  assign stat.j_last = ((CW'(j_r) + CW'(1)) == cnt_r);

  // Ordering test: smaller, or equal and earlier
  assign smaller = ($signed(rdata) < $signed(key_r)) || ((rdata == key_r) && (jd_r < i_r));
  assign disp    = i_r - rank_r;

  // Saturated pass count
  assign sum        = 32'(best_r) + 32'd1;
  assign passes_nxt = (sum > 32'(bspc_pkg::PASS_MAX)) ?
                      bspc_pkg::PASS_W'(bspc_pkg::PASS_MAX) : sum[bspc_pkg::PASS_W-1:0];

  // List fill count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.out_load) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  // Compare pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
    end
  end

  // Indices, key, rank and best displacement
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_r    <= '0;
      best_r <= '0;
    end else begin
      if (cmd.i_inc) begin
        i_r <= i_r + AW'(1);
      end
      if (cmd.eval && (i_r > rank_r) && (disp > best_r)) begin
        best_r <= disp;
      end
    end
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.scan) begin
      j_r <= j_r + AW'(1);
    end
    jd_r <= j_r;
    if (cmd.key_cap) begin
      key_r  <= rdata;
      rank_r <= '0;
    end else if (cmp_vld_r && smaller) begin
      rank_r <= rank_r + AW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      passes_r  <= passes_nxt;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_data = bspc_pkg::OUT_TDATA_W'(passes_r);
  assign out_ovf  = out_ovf_r;

endmodule

FILE: rtl/bspc_ctrl.sv
// Controller: load, rank sweep and result handoff sequencing.
`timescale 1ns / 1ps

module bspc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tlast,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  bspc_pkg::stat_t stat,
  output bspc_pkg::cmd_t  cmd
);

  bspc_pkg::state_t state_r;
  bspc_pkg::state_t state_nxt;
  logic             out_vld_r;
  logic             out_vld_nxt;
  logic             in_acc;
  logic             out_free;

  assign in_acc   = in_tvalid && (state_r == bspc_pkg::S_LOAD);
  assign out_free = !out_vld_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bspc_pkg::S_LOAD: begin
        if (in_acc && in_tlast) begin
          state_nxt = bspc_pkg::S_KEY;
        end
      end
      bspc_pkg::S_KEY:   state_nxt = bspc_pkg::S_KEYW;
      bspc_pkg::S_KEYW:  state_nxt = bspc_pkg::S_SCAN;
      bspc_pkg::S_SCAN: begin
        if (stat.j_last) begin
          state_nxt = bspc_pkg::S_DRAIN;
        end
      end
      bspc_pkg::S_DRAIN: state_nxt = bspc_pkg::S_EVAL;
      bspc_pkg::S_EVAL: begin
        state_nxt = stat.i_last ? bspc_pkg::S_OUT : bspc_pkg::S_KEY;
      end
      bspc_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = bspc_pkg::S_LOAD;
        end
      end
      default: state_nxt = bspc_pkg::S_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bspc_pkg::S_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_acc;
        cmd.start = in_acc && in_tlast;
      end
      bspc_pkg::S_KEY:  cmd.key_rd = 1'b1;
      bspc_pkg::S_KEYW: begin
        cmd.key_cap = 1'b1;
        cmd.j_clr   = 1'b1;
      end
      bspc_pkg::S_SCAN:  cmd.scan = 1'b1;
      bspc_pkg::S_DRAIN: cmd = '0;
      bspc_pkg::S_EVAL: begin
        cmd.eval  = 1'b1;
        cmd.i_inc = !stat.i_last;
      end
      bspc_pkg::S_OUT:   cmd.out_load = out_free;
      default:           cmd = '0;
    endcase
  end

  // Result valid: set on load, drop when the beat is taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bspc_pkg::S_LOAD;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;

endmodule

FILE: tb/tb_bubble_sort_pass_counter.sv
// Self-checking testbench of the bubble sort pass counter: list stimulus, pass-count predictor.
`timescale 1ns / 1ps

module tb_bubble_sort_pass_counter;

  // Watchdog bound: a full list ranks with no beat moving, so the limit must exceed its ranking time
  localparam int IDLE_LIMIT   = 4_000_000;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [bspc_pkg::VALUE_W-1:0] value;
    logic                         last;
  } in_beat_t;

  typedef struct {
    logic [bspc_pkg::PASS_W-1:0] passes;
    logic                        overflow;
  } pass_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [bspc_pkg::VALUE_W-1:0]     in_tdata = '0;     // [31:0] value
  logic                             in_tlast = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [bspc_pkg::OUT_TDATA_W-1:0] out_tdata;         // [10:0] passes, [15:11] zero
  logic                             out_tuser;         // [0] overflow

  // Stimulus and expectations
  in_beat_t                            item_q [$];
  pass_result_t                        passes_due_q [$];
  logic signed [bspc_pkg::VALUE_W-1:0] list_buf [$];

  // Predictor copy of the list state
  logic signed [bspc_pkg::VALUE_W-1:0] list_vals [bspc_pkg::MAX_ITEMS];
  int                     list_len = 0;
  logic                   list_dropped = 1'b0;

  int                     err_count = 0;
  int                     in_gap = 0;
  int                     out_gap = 0;
  int                     idle_cycles = 0;
  logic                   in_burst = 1'b0;
  logic                   out_burst = 1'b0;

  bubble_sort_pass_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Largest leftward displacement of the stored list, plus one
  function automatic logic [bspc_pkg::PASS_W-1:0] count_passes();
    int best;
    int rank;
    best = 0;
    for (int i = 0; i < list_len; i++) begin
      rank = 0;
      for (int j = 0; j < list_len; j++) begin
        if (list_vals[j] < list_vals[i] || (list_vals[j] == list_vals[i] && j < i))
          rank++;
      end
      if (i > rank && i - rank > best)
        best = i - rank;
    end
    if (best + 1 > bspc_pkg::PASS_MAX)
      return bspc_pkg::PASS_W'(bspc_pkg::PASS_MAX);
    return bspc_pkg::PASS_W'(best + 1);
  endfunction

  // Store or drop an accepted value; close the list on last
  task automatic predict_beat(input logic [bspc_pkg::VALUE_W-1:0] value, input logic last);
    pass_result_t res;
    if (list_len < bspc_pkg::MAX_ITEMS) begin
      list_vals[list_len] = value;
      list_len++;
    end else begin
      list_dropped = 1'b1;
    end
    if (last) begin
      res.passes   = count_passes();
      res.overflow = list_dropped;
      passes_due_q.push_back(res);
      list_len     = 0;
      list_dropped = 1'b0;
    end
  endtask

  // Insertion sort of the list buffer, signed order
  task automatic sort_buf(input bit descending);
    logic signed [bspc_pkg::VALUE_W-1:0] key;
    int j;
    for (int i = 1; i < list_buf.size(); i++) begin
      key = list_buf[i];
      j = i - 1;
      while (j >= 0 && (descending ? list_buf[j] < key : list_buf[j] > key)) begin
        list_buf[j + 1] = list_buf[j];
        j--;
      end
      list_buf[j + 1] = key;
    end
  endtask

  // Queue the buffered list, last flag on its final value
  task automatic flush_list();
    in_beat_t beat;
    for (int i = 0; i < list_buf.size(); i++) begin
      beat.value = list_buf[i];
      beat.last  = (i == list_buf.size() - 1);
      item_q.push_back(beat);
    end
    list_buf.delete();
  endtask

  // Random list: full-range or clustered values, in random, sorted or near-sorted order
  task automatic add_random_list(input int n);
    int src;
    int order;
    int a;
    int b;
    logic signed [bspc_pkg::VALUE_W-1:0] tmp;
    src   = $urandom_range(0, 2);
    order = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (src == 0) list_buf.push_back($urandom);
      else list_buf.push_back($signed(bspc_pkg::VALUE_W'($urandom_range(0, 8))) - 4);
    end
    if (order == 1 || order == 3) sort_buf(1'b0);
    if (order == 2) sort_buf(1'b1);
    // Near-sorted: swap two entries so one value travels far
    if (order == 3 && n > 1) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      tmp = list_buf[a];
      list_buf[a] = list_buf[b];
      list_buf[b] = tmp;
    end
    flush_list();
  endtask

  // Input driver: hold each beat until accepted, then apply a gap
  always @(posedge clk) begin : drive_in
    in_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready)
        predict_beat(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (item_q.size() != 0) begin
          beat = item_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= beat.value;
          in_tlast  <= beat.last;
          in_gap = in_burst ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest expectation, stall at random
  always @(posedge clk) begin : watch_out
    pass_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (passes_due_q.size() == 0) begin
          $display("%0t: unexpected result: passes %0d overflow %0b",
                   $time, out_tdata[bspc_pkg::PASS_W-1:0], out_tuser);
          err_count++;
        end else begin
          want = passes_due_q.pop_front();
          if (out_tdata[bspc_pkg::PASS_W-1:0] !== want.passes) begin
            $display("%0t: passes mismatch: expected %0d actual %0d",
                     $time, want.passes, out_tdata[bspc_pkg::PASS_W-1:0]);
            err_count++;
          end
          if (out_tuser !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %0b actual %0b",
                     $time, want.overflow, out_tuser);
            err_count++;
          end
        end
      end
      if (out_gap == 0 && !out_burst && $urandom_range(0, 3) == 0)
        out_gap = pick_gap();
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Toggle stretches without idling on either side
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) in_burst <= ~in_burst;
    if ($urandom_range(0, 299) == 0) out_burst <= ~out_burst;
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("bubble_sort_pass_counter verification failed");
        $finish;
      end
    end
  end

  initial begin
    int rand_items;
    int n;
    int r;

    // Single value
    list_buf.push_back(32'sd0);
    flush_list();
    // Extremes, largest first
    list_buf.push_back(32'sh7FFF_FFFF);
    list_buf.push_back(32'sh8000_0000);
    flush_list();
    // Already sorted
    list_buf.push_back(32'sh8000_0000);
    list_buf.push_back(-32'sd1);
    list_buf.push_back(32'sd0);
    list_buf.push_back(32'sd1);
    list_buf.push_back(32'sh7FFF_FFFF);
    flush_list();
    // Reversed
    list_buf.push_back(32'sh7FFF_FFFF);
    list_buf.push_back(32'sd1);
    list_buf.push_back(32'sd0);
    list_buf.push_back(-32'sd1);
    list_buf.push_back(32'sh8000_0000);
    flush_list();
    // All equal: ties keep arrival order
    repeat (4) list_buf.push_back(32'sd5);
    flush_list();
    // Repeated values and alternating bit patterns
    list_buf.push_back(32'sd3);
    list_buf.push_back(-32'sd3);
    list_buf.push_back(32'sd3);
    list_buf.push_back(-32'sd3);
    list_buf.push_back(32'sh5555_5555);
    list_buf.push_back(32'shAAAA_AAAA);
    flush_list();

    // Full store in descending order, then two dropped values, the last one closing the list
    for (int i = 0; i < bspc_pkg::MAX_ITEMS; i++) list_buf.push_back($urandom);
    sort_buf(1'b1);
    list_buf.push_back($urandom);
    list_buf.push_back($urandom);
    flush_list();

    // Random lists, mostly short, a few long
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 8);
      else if (r < 95) n = $urandom_range(9, 40);
      else n = $urandom_range(41, 120);
      add_random_list(n);
      rand_items += n;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the driver's updates have settled
    @(negedge clk);
    while (item_q.size() != 0 || in_tvalid || passes_due_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("bubble_sort_pass_counter verification clean");
    end else begin
      $display("bubble_sort_pass_counter verification failed");
    end
    $finish;
  end

endmodule
